@@ src/mos_pkg.sv @@
// shared types and sizing constants for the median-of-set sorter
package mos_pkg;

    // capacity of the sorter chain and width of one stored value
    localparam int MAX_COUNT  = 64;
    localparam int DATA_WIDTH = 32;

    // count register holds 0 .. MAX_COUNT
    localparam int COUNT_W = $clog2(MAX_COUNT + 1);

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [COUNT_W-1:0]    t_count;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic  insert;  // place value into the sorted row
        logic  shift;   // move every value one cell toward the head
        t_data value;   // item being inserted
    } t_chain_ctl;

endpackage

@@ src/mos_cell.sv @@
// one cell of the insertion sorter: holds a value and passes it to its neighbors
module mos_cell (
    input  logic                i_clk,
    input  mos_pkg::t_chain_ctl i_ctl,
    input  logic                i_occupied,
    input  mos_pkg::t_data      i_prev_val,
    input  logic                i_prev_cmp,
    input  mos_pkg::t_data      i_next_val,
    output mos_pkg::t_data      o_val,
    output logic                o_cmp
);

    mos_pkg::t_data r_val;
    mos_pkg::t_data n_val;
    logic           w_cmp;

    // new item goes before this cell's value (empty cells count as larger)
    assign w_cmp = !i_occupied || ($signed(i_ctl.value) < $signed(r_val));

    // insert: take the left neighbor's value if it moves too, else the new item
    always_comb begin
        n_val = r_val;
        if (i_ctl.insert) begin
            if (w_cmp) begin
                n_val = i_prev_cmp ? i_prev_val : i_ctl.value;
            end
        end else if (i_ctl.shift) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_cmp = w_cmp;

endmodule

@@ src/mos_chain.sv @@
// row of sorter cells, kept in ascending order from the head
module mos_chain (
    input  logic                i_clk,
    input  mos_pkg::t_chain_ctl i_ctl,
    input  mos_pkg::t_count     i_count,
    output mos_pkg::t_data      o_head,
    output mos_pkg::t_data      o_second
);

    mos_pkg::t_data w_val [mos_pkg::MAX_COUNT];
    logic           w_cmp [mos_pkg::MAX_COUNT];

    genvar gi;
    generate
        for (gi = 0; gi < mos_pkg::MAX_COUNT; gi++) begin : g_cell
            mos_pkg::t_data w_prev_val;
            logic           w_prev_cmp;
            mos_pkg::t_data w_next_val;
            logic           w_occ;

            // neighbor links, with fixed ends at the head and the tail
            if (gi == 0) begin : g_head
                assign w_prev_val = '0;
                assign w_prev_cmp = 1'b0;
            end else begin : g_body
                assign w_prev_val = w_val[gi-1];
                assign w_prev_cmp = w_cmp[gi-1];
            end
            if (gi == mos_pkg::MAX_COUNT - 1) begin : g_tail
                assign w_next_val = w_val[gi];
            end else begin : g_inner
                assign w_next_val = w_val[gi+1];
            end

            // cells below the fill count hold live values
            assign w_occ = (mos_pkg::COUNT_W'(gi) < i_count);

            mos_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (i_ctl),
                .i_occupied (w_occ),
                .i_prev_val (w_prev_val),
                .i_prev_cmp (w_prev_cmp),
                .i_next_val (w_next_val),
                .o_val      (w_val[gi]),
                .o_cmp      (w_cmp[gi])
            );
        end

        // the two head cells feed the median arithmetic
        if (mos_pkg::MAX_COUNT > 1) begin : g_two
            assign o_second = w_val[1];
        end else begin : g_one
            assign o_second = w_val[0];
        end
    endgenerate

    assign o_head = w_val[0];

endmodule

@@ src/median_of_set_core.sv @@
// median of a streamed set: insertion-sort cell chain plus drain sequencer
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  input   | in        | i_in_valid / o_in_stall  | i_sample_value, i_has_value, i_last
//  result  | out       | o_out_valid / i_out_stall| o_median_value, o_set_count,
//          |           |                        | o_overflowed, o_empty_set
//
// an item without last needs no drain: the cell chain inserts a value per cycle
// while the sequencer is idle. an item with last closes the set; the chain then shifts
// toward its head until the middle values reach the first two cells, the sequencer
// leaves the shift state, and the output state loads the result register once it is
// free.
// reset clears the fill count, shift count, drop flag, sequencer and result valid; cell
// contents need no reset. a pending result does not block new items, but the
// next closing item waits in the drain until the result register is free.
module median_of_set_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_sample_value,
    input  logic        i_has_value,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_median_value,
    output logic [6:0]  o_set_count,
    output logic        o_overflowed,
    output logic        o_empty_set
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_OUT
    } t_state;

    t_state               r_state;
    mos_pkg::t_count      r_count;
    mos_pkg::t_count      r_shift;
    logic                 r_drop;
    logic                 r_out_valid;
    logic [31:0]          r_median;
    logic [6:0]           r_set_count;
    logic                 r_overflowed;
    logic                 r_empty;

    mos_pkg::t_chain_ctl  w_ctl;
    mos_pkg::t_data       w_head;
    mos_pkg::t_data       w_second;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_do_insert;
    mos_pkg::t_count      w_new_count;
    logic                 w_out_free;
    logic [mos_pkg::DATA_WIDTH:0] w_sum;
    mos_pkg::t_data       w_med;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == mos_pkg::COUNT_W'(mos_pkg::MAX_COUNT));
    assign w_do_insert = w_accept && i_has_value && !w_full;
    assign w_new_count = w_do_insert ? (r_count + 1'b1) : r_count;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // chain control
    always_comb begin
        w_ctl.insert = w_do_insert;
        w_ctl.shift  = (r_state == S_SHIFT) && (r_shift != '0);
        w_ctl.value  = mos_pkg::DATA_WIDTH'(i_sample_value);
    end

    mos_chain u_chain (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_count  (r_count),
        .o_head   (w_head),
        .o_second (w_second)
    );

    // median from the two head cells: middle value, or floor of the pair mean; zero for an empty set
    always_comb begin
        w_sum = {w_head[mos_pkg::DATA_WIDTH-1], w_head}
              + {w_second[mos_pkg::DATA_WIDTH-1], w_second};
        if (r_count == '0) begin
            w_med = '0;
        end else if (r_count[0]) begin
            w_med = w_head;
        end else begin
            w_med = w_sum[mos_pkg::DATA_WIDTH:1];
        end
    end

    // sequencer, fill count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_shift     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the drain state reloads the result register itself
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= w_new_count;
                        if (i_has_value && w_full) begin
                            r_drop <= 1'b1;
                        end
                        if (i_last) begin
                            r_shift <= (w_new_count == '0) ? '0
                                     : ((w_new_count - 1'b1) >> 1);
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_shift != '0) begin
                        r_shift <= r_shift - 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_median     <= 32'($signed(w_med));
                        r_set_count  <= 7'(r_count);
                        r_overflowed <= r_drop;
                        r_empty      <= (r_count == '0);
                        r_out_valid  <= 1'b1;
                        r_count      <= '0;
                        r_drop       <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_median_value = r_median;
    assign o_set_count    = r_set_count;
    assign o_overflowed   = r_overflowed;
    assign o_empty_set    = r_empty;

endmodule

@@ test/median_of_set_core_tb.sv @@
// testbench for median_of_set_core: streamed sets checked against a sorted-set median predictor
module median_of_set_core_tb;

    // one expected median result
    typedef struct packed {
        mos_pkg::t_data  median;
        mos_pkg::t_count count;
        logic            ovf;
        logic            empty;
    } t_median_exp;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [31:0] i_sample_value = '0;
    logic        i_has_value    = 1'b0;
    logic        i_last         = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_median_value;
    logic [6:0]  o_set_count;
    logic        o_overflowed;
    logic        o_empty_set;

    // predictor copy of the sorted set
    mos_pkg::t_data kept_vals [mos_pkg::MAX_COUNT];
    int             kept_n        = 0;
    logic           kept_dropped  = 1'b0;
    t_median_exp    medians_due[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int mismatch_cnt   = 0;

    always #5 i_clk = ~i_clk;

    median_of_set_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_value (i_sample_value),
        .i_has_value    (i_has_value),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_median_value (o_median_value),
        .o_set_count    (o_set_count),
        .o_overflowed   (o_overflowed),
        .o_empty_set    (o_empty_set)
    );

    // median of the kept values, even count rounds toward minus infinity
    function automatic mos_pkg::t_data median_of_kept();
        logic signed [32:0] pair_sum;
        mos_pkg::t_data lo_val;
        mos_pkg::t_data hi_val;
        if (kept_n == 0) return '0;
        if (kept_n % 2 == 1) return kept_vals[kept_n / 2];
        lo_val   = kept_vals[kept_n / 2 - 1];
        hi_val   = kept_vals[kept_n / 2];
        pair_sum = $signed(lo_val) + $signed(hi_val);
        return pair_sum[32:1];
    endfunction

    // insert an accepted value and close the set on last
    function automatic void fold_into_set(mos_pkg::t_data v, logic has, logic last);
        int pos;
        t_median_exp due;
        if (has) begin
            if (kept_n >= mos_pkg::MAX_COUNT) begin
                kept_dropped = 1'b1;
            end else begin
                pos = kept_n;
                while (pos > 0 && $signed(v) < $signed(kept_vals[pos - 1])) begin
                    kept_vals[pos] = kept_vals[pos - 1];
                    pos--;
                end
                kept_vals[pos] = v;
                kept_n++;
            end
        end
        if (last) begin
            due.median = median_of_kept();
            due.count  = mos_pkg::t_count'(kept_n);
            due.ovf    = kept_dropped;
            due.empty  = (kept_n == 0);
            medians_due.insert(medians_due.size(), due);
            kept_n       = 0;
            kept_dropped = 1'b0;
        end
    endfunction

    // offer one item, hold it until accepted
    task automatic send_item(mos_pkg::t_data v, logic has, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= v;
        i_has_value    <= has;
        i_last         <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fold_into_set(v, has, last);
        if (has || last) items_sent++;
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    // wait for every pending median, bounded
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (medians_due.size() > 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // values biased toward edges and duplicates
    function automatic mos_pkg::t_data random_value();
        case ($urandom_range(19))
            0, 1: begin
                case ($urandom_range(4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            2, 3, 4: return mos_pkg::t_data'(int'($urandom_range(16)) - 8);
            5:       return 32'h8000_0000 + $urandom_range(3);
            6:       return 32'h7FFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // mostly short sets, a few full or overfull
    function automatic int random_set_size();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(8);
        if (r < 95) return $urandom_range(40, 9);
        if (r < 99) return $urandom_range(64, 41);
        return $urandom_range(72, 65);
    endfunction

    // one set with random content, closed on the last value or by a bare marker
    task automatic send_random_set(int n);
        logic close_on_value;
        close_on_value = 1'b0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) send_item(random_value(), 1'b0, 1'b0);
            close_on_value = (i == n - 1) && $urandom_range(1);
            send_item(random_value(), 1'b1, close_on_value);
        end
        if (!close_on_value) send_item(random_value(), 1'b0, 1'b1);
    endtask

    // edges of the value range and each special case of a set
    task automatic test_directed();
        send_item(32'h1234_5678, 1'b0, 1'b1);   // empty set
        send_item(32'hFFFF_FFFF, 1'b0, 1'b0);   // idle item
        send_item(32'h7FFF_FFFF, 1'b1, 1'b1);   // single value with last
        send_item(32'h8000_0000, 1'b1, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b1, 1'b0);   // even pair at the top
        send_item(32'h7FFF_FFFF, 1'b1, 1'b1);
        send_item(32'h8000_0000, 1'b1, 1'b0);   // even pair at the bottom
        send_item(32'h8000_0000, 1'b1, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b1, 1'b0);   // min and max, floor of -1/2
        send_item(32'h8000_0000, 1'b1, 1'b1);
        send_item(32'h0000_0001, 1'b1, 1'b0);   // both odd, carry into the mean
        send_item(32'h0000_0003, 1'b1, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b0);   // negative half rounds down
        send_item(32'hFFFF_FFFE, 1'b1, 1'b1);
        send_item(32'h0005_0000, 1'b1, 1'b0);   // values out of order, bare marker
        send_item(32'hFFFB_0000, 1'b1, 1'b0);
        send_item(32'h0000_0000, 1'b1, 1'b0);
        send_item(32'h0000_0000, 1'b0, 1'b1);
        send_item(32'h0000_0001, 1'b1, 1'b0);   // idle item inside a set
        send_item(32'h5555_AAAA, 1'b0, 1'b0);
        send_item(32'hAAAA_5555, 1'b1, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
        stop_sending();
        wait_drained();
    endtask

    // exactly full, then two overfull sets with values dropped past capacity
    task automatic test_store_full();
        send_idle_pct  = 5;
        recv_stall_pct = 20;
        for (int i = 0; i < mos_pkg::MAX_COUNT; i++)
            send_item(random_value(), 1'b1, i == mos_pkg::MAX_COUNT - 1);
        for (int i = 0; i < mos_pkg::MAX_COUNT + 5; i++)
            send_item(random_value(), 1'b1, i == mos_pkg::MAX_COUNT + 4);
        for (int i = 0; i < mos_pkg::MAX_COUNT + 2; i++)
            send_item(random_value(), 1'b1, 1'b0);
        send_item(random_value(), 1'b0, 1'b1);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_traffic(int sender_pct, int receiver_pct, int item_goal);
        int first_item;
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        first_item     = items_sent;
        while (items_sent - first_item < item_goal) send_random_set(random_set_size());
        stop_sending();
        wait_drained();
    endtask

    // receiver holds off while sets keep coming, so the input stalls
    task automatic test_result_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (4) send_random_set($urandom_range(6, 1));
        stop_sending();
        wait_drained();
    endtask

    // sender waits for every median before the next set
    task automatic test_paused_sender();
        send_idle_pct  = 10;
        recv_stall_pct = 30;
        repeat (5) begin
            send_random_set(random_set_size());
            stop_sending();
            wait_drained();
        end
    endtask

    // receiver stall, random or held off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // compare each accepted result with the oldest expected median
    always @(posedge i_clk) begin
        t_median_exp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (medians_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("result with no set closed: median=%0d count=%0d ovf=%0b empty=%0b",
                             $signed(o_median_value), o_set_count, o_overflowed, o_empty_set);
            end else begin
                want = medians_due.pop_front();
                if (o_median_value !== want.median || o_set_count !== want.count ||
                    o_overflowed !== want.ovf || o_empty_set !== want.empty) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("median mismatch: exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                 $signed(want.median), want.count, want.ovf, want.empty,
                                 $signed(o_median_value), o_set_count, o_overflowed,
                                 o_empty_set);
                end
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_store_full();
        test_random_traffic(9, 70, 360);
        test_random_traffic(70, 9, 360);
        test_random_traffic(0, 0, 360);
        test_result_holdoff();
        test_paused_sender();

        // let any late result show up
        wait_drained();
        repeat (60) @(posedge i_clk);
        mismatch_cnt += medians_due.size();
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/mos_pkg.sv
src/mos_cell.sv
src/mos_chain.sv
src/median_of_set_core.sv
test/median_of_set_core_tb.sv
